[rtl/isingr_pkg.sv]
package isingr_pkg;

  localparam int NUM_RINGS       = 1024;
  localparam int RING_AW         = $clog2(NUM_RINGS);
  localparam int MAX_RING_LENGTH = 64;

  localparam int MODE_W    = 2;
  localparam int SITE_W    = 6;
  localparam int UNI_W     = 24;
  localparam int SPIN_W    = 64;
  localparam int DE_W      = 4;
  localparam int SUM_W     = 8;
  localparam int LEN_W     = 7;
  localparam int THR_W     = 25;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = THR_W;

  localparam int CHUNK_W     = 8;
  localparam int NUM_CHUNKS  = SPIN_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);
  localparam int CNT_W       = $clog2(SPIN_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THRESHOLD = 1'd1;

  localparam logic [LEN_W-1:0] RING_LENGTH_RESET      = 7'd50;
  localparam logic [THR_W-1:0] ACCEPT_THRESHOLD_RESET = 25'd307285;
  localparam logic [LEN_W-1:0] RING_LENGTH_MIN        = 7'd3;
  localparam logic [LEN_W-1:0] RING_LENGTH_MAX        = LEN_W'(MAX_RING_LENGTH);

  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLIP = 2'd1;

  localparam logic signed [DE_W-1:0] DE_RISE = 4'sd4;
  localparam logic signed [DE_W-1:0] DE_FALL = -4'sd4;
  localparam logic signed [DE_W-1:0] DE_ZERO = 4'sd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_COUNT,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] energy;
    logic signed [SUM_W-1:0] magnetisation;
  } stats_t;

endpackage

[rtl/isingr_in_if.sv]
interface isingr_in_if import isingr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [RING_AW-1:0]  ring_index;
  logic [SITE_W-1:0]   site_index;
  logic [UNI_W-1:0]    uniform_value;
  logic [SPIN_W-1:0]   spin_word;

  modport source (
    output valid, mode, ring_index, site_index, uniform_value, spin_word,
    input  ready
  );

  modport sink (
    input  valid, mode, ring_index, site_index, uniform_value, spin_word,
    output ready
  );
endinterface

[rtl/isingr_out_if.sv]
interface isingr_out_if import isingr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic signed [DE_W-1:0]  delta_energy;
  logic [SPIN_W-1:0]       ring_spins;
  logic signed [SUM_W-1:0] ring_energy;
  logic signed [SUM_W-1:0] ring_magnetisation;
  logic                    site_error;

  modport source (
    output valid, accepted, delta_energy, ring_spins, ring_energy,
           ring_magnetisation, site_error,
    input  ready
  );

  modport sink (
    input  valid, accepted, delta_energy, ring_spins, ring_energy,
           ring_magnetisation, site_error,
    output ready
  );
endinterface

[rtl/isingr_ram.sv]
module isingr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/isingr_stats.sv]
module isingr_stats import isingr_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [SPIN_W-1:0] word_i,
  input  logic [LEN_W-1:0]  len_i,
  output stats_t            stats_o
);

  logic [SPIN_W-1:0]      spin_vec;
  logic [SPIN_W-1:0]      mism_vec;
  logic                   wrap_mism;
  logic [LEN_W-1:0]       len_m1;
  logic [CHUNK_CNT_W-1:0] up_cnt_d   [NUM_CHUNKS];
  logic [CHUNK_CNT_W-1:0] mism_cnt_d [NUM_CHUNKS];
  logic [CHUNK_CNT_W-1:0] up_cnt_q   [NUM_CHUNKS];
  logic [CHUNK_CNT_W-1:0] mism_cnt_q [NUM_CHUNKS];
  logic [CNT_W-1:0]       up_total;
  logic [CNT_W-1:0]       mism_total;

  assign len_m1    = len_i - LEN_W'(1);
  assign wrap_mism = word_i[len_m1[SITE_W-1:0]] ^ word_i[0];

  // Keep only sites below the ring length; pair L-1 closes the ring to site 0.
  always_comb begin
    for (int i = 0; i < SPIN_W; i++) begin
      spin_vec[i] = (LEN_W'(i) < len_i) ? word_i[i] : 1'b0;
      if (LEN_W'(i) < len_m1) begin
        mism_vec[i] = word_i[i] ^ word_i[(i + 1) % SPIN_W];
      end else if (LEN_W'(i) == len_m1) begin
        mism_vec[i] = wrap_mism;
      end else begin
        mism_vec[i] = 1'b0;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      up_cnt_d[c]   = '0;
      mism_cnt_d[c] = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
        up_cnt_d[c]   = up_cnt_d[c] + CHUNK_CNT_W'(spin_vec[c*CHUNK_W + b]);
        mism_cnt_d[c] = mism_cnt_d[c] + CHUNK_CNT_W'(mism_vec[c*CHUNK_W + b]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      up_cnt_q   <= up_cnt_d;
      mism_cnt_q <= mism_cnt_d;
    end
  end

  always_comb begin
    up_total   = '0;
    mism_total = '0;
    for (int c = 0; c < NUM_CHUNKS; c++) begin
      up_total   = up_total + CNT_W'(up_cnt_q[c]);
      mism_total = mism_total + CNT_W'(mism_cnt_q[c]);
    end
  end

  // energy = 2*mismatches - L, magnetisation = L - 2*up
  always_comb begin
    logic signed [SUM_W:0] energy_w;
    logic signed [SUM_W:0] mag_w;
    energy_w = $signed({1'b0, mism_total, 1'b0}) - $signed({2'b00, len_i});
    mag_w    = $signed({2'b00, len_i}) - $signed({1'b0, up_total, 1'b0});
    stats_o.energy        = energy_w[SUM_W-1:0];
    stats_o.magnetisation = mag_w[SUM_W-1:0];
  end

endmodule

[rtl/ising_ring_metropolis_update.sv]
// Channel   Dir  Transaction payload
// item_i    in   mode, ring_index, site_index, uniform_value, spin_word
// result_o  out  accepted, delta_energy, ring_spins, ring_energy,
//                ring_magnetisation, site_error
// cfg       in   cfg_we_i, cfg_index_i, cfg_wdata_i (write only)
//
// After acceptance the item passes evaluate and write back on the word read at
// acceptance, per-byte counts, and final sums into the output register.
// One item is in flight at a time, so a new item is not accepted until the
// previous result has reached the output register; it is accepted even while
// that result is unclaimed.
// A stalled output holds the finished item in the sum stage.
// Reset clears control and configuration; ring memory is undefined until loaded.
module ising_ring_metropolis_update import isingr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  isingr_in_if.sink            item_i,
  isingr_out_if.source         result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]  ring_length_q;
  logic [THR_W-1:0]  accept_threshold_q;
  logic [LEN_W-1:0]  eff_len;

  logic [MODE_W-1:0]  mode_q;
  logic [RING_AW-1:0] ring_q;
  logic [SITE_W-1:0]  site_q;
  logic [UNI_W-1:0]   uni_q;
  logic [SPIN_W-1:0]  load_word_q;

  logic [SPIN_W-1:0]      word_q, word_d;
  logic                   acc_q, acc_d;
  logic                   err_q, err_d;
  logic signed [DE_W-1:0] de_q, de_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_acc_q;
  logic                   out_err_q;
  logic signed [DE_W-1:0] out_de_q;
  logic [SPIN_W-1:0]      out_word_q;
  stats_t                 out_stats_q;

  logic              in_fire;
  logic              eval_en;
  logic              count_en;
  logic              result_load;
  logic              ram_we;
  logic [SPIN_W-1:0] ram_rdata;
  stats_t            stats;

  logic              site_ok;
  logic [LEN_W-1:0]  len_m1;
  logic [SITE_W-1:0] left_idx;
  logic [SITE_W-1:0] right_idx;
  logic              s_mid, s_left, s_right;
  logic              rise, fall, flip_ok;

  assign eff_len = (ring_length_q < RING_LENGTH_MIN) ? RING_LENGTH_MIN :
                   (ring_length_q > RING_LENGTH_MAX) ? RING_LENGTH_MAX : ring_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_length_q      <= RING_LENGTH_RESET;
      accept_threshold_q <= ACCEPT_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RING_LENGTH:      ring_length_q      <= cfg_wdata_i[LEN_W-1:0];
        CFG_ACCEPT_THRESHOLD: accept_threshold_q <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_fire      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q      <= item_i.mode;
      ring_q      <= item_i.ring_index;
      site_q      <= item_i.site_index;
      uni_q       <= item_i.uniform_value;
      load_word_q <= item_i.spin_word;
    end
  end

  isingr_ram #(
    .WIDTH (SPIN_W),
    .DEPTH (NUM_RINGS)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ring_q),
    .wdata_i (word_d),
    .raddr_i (item_i.ring_index),
    .rdata_o (ram_rdata)
  );

  // Flip trial against the word just read.
  assign len_m1    = eff_len - LEN_W'(1);
  assign site_ok   = {1'b0, site_q} < eff_len;
  assign left_idx  = (site_q == '0) ? len_m1[SITE_W-1:0] : site_q - SITE_W'(1);
  assign right_idx = ({1'b0, site_q} == len_m1) ? '0 : site_q + SITE_W'(1);
  assign s_mid     = ram_rdata[site_q];
  assign s_left    = ram_rdata[left_idx];
  assign s_right   = ram_rdata[right_idx];
  assign rise      = (s_left == s_mid) && (s_right == s_mid);
  assign fall      = (s_left != s_mid) && (s_right != s_mid);
  assign flip_ok   = site_ok && (!rise || ({1'b0, uni_q} < accept_threshold_q));

  always_comb begin
    word_d = ram_rdata;
    acc_d  = 1'b0;
    err_d  = 1'b0;
    de_d   = DE_ZERO;
    case (mode_q)
      MODE_LOAD: begin
        word_d = load_word_q;
      end
      MODE_FLIP: begin
        err_d = !site_ok;
        acc_d = flip_ok;
        if (site_ok) begin
          de_d = rise ? DE_RISE : (fall ? DE_FALL : DE_ZERO);
        end
        if (flip_ok) begin
          word_d = ram_rdata ^ (SPIN_W'(1) << site_q);
        end
      end
      default: ;
    endcase
  end

  assign ram_we = eval_en && ((mode_q == MODE_LOAD) || ((mode_q == MODE_FLIP) && flip_ok));

  always_ff @(posedge clk_i) begin
    if (eval_en) begin
      word_q <= word_d;
      acc_q  <= acc_d;
      err_q  <= err_d;
      de_q   <= de_d;
    end
  end

  isingr_stats u_stats (
    .clk_i   (clk_i),
    .load_i  (count_en),
    .word_i  (word_q),
    .len_i   (eff_len),
    .stats_o (stats)
  );

  always_comb begin
    state_d     = state_q;
    eval_en     = 1'b0;
    count_en    = 1'b0;
    result_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        eval_en = 1'b1;
        state_d = ST_COUNT;
      end
      ST_COUNT: begin
        count_en = 1'b1;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        // hold until the output register is free
        if (!out_valid_q || result_o.ready) begin
          result_load = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) out_valid_d = 1'b0;
    if (result_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_load) begin
      out_acc_q   <= acc_q;
      out_err_q   <= err_q;
      out_de_q    <= de_q;
      out_word_q  <= word_q;
      out_stats_q <= stats;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.accepted           = out_acc_q;
  assign result_o.delta_energy       = out_de_q;
  assign result_o.ring_spins         = out_word_q;
  assign result_o.ring_energy        = out_stats_q.energy;
  assign result_o.ring_magnetisation = out_stats_q.magnetisation;
  assign result_o.site_error         = out_err_q;

endmodule

[bench/ising_ring_checker.sv]
`timescale 1ns / 1ps

module ising_ring_checker import isingr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  isingr_in_if                 item_mon,
  isingr_out_if                result_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic                    accepted;
    logic signed [DE_W-1:0]  delta_energy;
    logic [SPIN_W-1:0]       ring_spins;
    logic signed [SUM_W-1:0] ring_energy;
    logic signed [SUM_W-1:0] ring_magnetisation;
    logic                    site_error;
  } ring_result_t;

  logic [SPIN_W-1:0] spin_mem [NUM_RINGS];
  logic [LEN_W-1:0]  ring_len_q;
  logic [THR_W-1:0]  threshold_q;
  ring_result_t      expected_updates [$];
  int                mismatches;

  function automatic int active_sites();
    if (ring_len_q < RING_LENGTH_MIN) return int'(RING_LENGTH_MIN);
    if (ring_len_q > RING_LENGTH_MAX) return int'(RING_LENGTH_MAX);
    return int'(ring_len_q);
  endfunction

  function automatic int spin_of(input logic b);
    return b ? 1 : -1;
  endfunction

  // Energy is minus the bond sum; magnetisation is minus the spin sum.
  function automatic void ring_stats(input logic [SPIN_W-1:0] w, input int n,
                                     output int energy, output int mag);
    int bonds;
    int ones;
    int j;
    bonds = 0;
    ones  = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      bonds += (w[i] == w[j]) ? 1 : -1;
      ones  += int'(w[i]);
    end
    energy = -bonds;
    mag    = n - 2 * ones;
  endfunction

  function automatic ring_result_t apply_item(input logic [MODE_W-1:0] mode,
                                              input logic [RING_AW-1:0] ring,
                                              input logic [SITE_W-1:0] site,
                                              input logic [UNI_W-1:0]  uni,
                                              input logic [SPIN_W-1:0] word);
    ring_result_t      res;
    logic [SPIN_W-1:0] w;
    int                n;
    int                s;
    int                left;
    int                right;
    int                de;
    int                energy;
    int                mag;
    res = '0;
    n   = active_sites();
    s   = int'(site);
    if (mode == MODE_LOAD) begin
      spin_mem[ring] = word;
    end else if (mode == MODE_FLIP) begin
      w = spin_mem[ring];
      if (s >= n) begin
        res.site_error = 1'b1;
      end else begin
        left  = (s == 0) ? n - 1 : s - 1;
        right = (s + 1 == n) ? 0 : s + 1;
        de    = 2 * spin_of(w[s]) * (spin_of(w[left]) + spin_of(w[right]));
        res.delta_energy = DE_W'(de);
        if (de <= 0 || {1'b0, uni} < threshold_q) begin
          res.accepted   = 1'b1;
          spin_mem[ring] = w ^ (64'd1 << s);
        end
      end
    end
    ring_stats(spin_mem[ring], n, energy, mag);
    res.ring_spins         = spin_mem[ring];
    res.ring_energy        = SUM_W'(energy);
    res.ring_magnetisation = SUM_W'(mag);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [SPIN_W-1:0] want,
                             input logic [SPIN_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t want;
    if (!rst_ni) begin
      ring_len_q  = RING_LENGTH_RESET;
      threshold_q = ACCEPT_THRESHOLD_RESET;
      expected_updates.delete();
      mismatches  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_RING_LENGTH) ring_len_q = cfg_wdata_i[LEN_W-1:0];
        else if (cfg_index_i == CFG_ACCEPT_THRESHOLD) threshold_q = cfg_wdata_i[THR_W-1:0];
      end
      if (item_mon.valid && item_mon.ready) begin
        expected_updates.push_back(apply_item(item_mon.mode, item_mon.ring_index,
                                              item_mon.site_index, item_mon.uniform_value,
                                              item_mon.spin_word));
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_updates.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction with nothing outstanding, expected none actual %h",
                   $time, result_mon.ring_spins);
        end else begin
          want = expected_updates.pop_front();
          check_field("accepted", SPIN_W'(want.accepted), SPIN_W'(result_mon.accepted));
          check_field("delta_energy", SPIN_W'(want.delta_energy),
                      SPIN_W'(result_mon.delta_energy));
          check_field("ring_spins", want.ring_spins, result_mon.ring_spins);
          check_field("ring_energy", SPIN_W'(want.ring_energy),
                      SPIN_W'(result_mon.ring_energy));
          check_field("ring_magnetisation", SPIN_W'(want.ring_magnetisation),
                      SPIN_W'(result_mon.ring_magnetisation));
          check_field("site_error", SPIN_W'(want.site_error), SPIN_W'(result_mon.site_error));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_updates.size();
    end
  end

endmodule

[bench/tb_ising_ring_metropolis_update.sv]
`timescale 1ns / 1ps

module tb_ising_ring_metropolis_update;
  import isingr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_READ     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ_ALT = 2'd3;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int THR_ONE         = 1 << UNI_W;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   fail_count;
  int                   pending;
  int unsigned          cycle_count = 0;

  // Stimulus-side view of the block's setup and of which rings hold data.
  int                   cur_sites;
  int                   cur_thr;
  bit                   ring_loaded [NUM_RINGS];
  int                   loaded_rings [$];
  int                   last_ring;
  bit                   idle_off;
  bit                   sink_hold_req;

  isingr_in_if  item_if ();
  isingr_out_if result_if ();

  ising_ring_metropolis_update dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  ising_ring_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_if),
    .result_mon   (result_if),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_ring();
    if ($urandom_range(0, 1) == 0) return last_ring;
    return loaded_rings[$urandom_range(0, loaded_rings.size() - 1)];
  endfunction

  // Valid stays high after a transaction; the next call either replaces the
  // payload in the same step or drops valid for a gap.
  task automatic send_item(input logic [MODE_W-1:0] mode, input int ring,
                           input logic [SITE_W-1:0] site, input logic [UNI_W-1:0] uni,
                           input logic [SPIN_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid         <= 1'b1;
    item_if.mode          <= mode;
    item_if.ring_index    <= RING_AW'(ring);
    item_if.site_index    <= site;
    item_if.uniform_value <= uni;
    item_if.spin_word     <= word;
    if (mode == MODE_LOAD && !ring_loaded[ring]) begin
      ring_loaded[ring] = 1'b1;
      loaded_rings.push_back(ring);
    end
    last_ring = ring;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
  endtask

  task automatic drain_results();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input int len, input int thr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RING_LENGTH;
    cfg_wdata <= CFG_W'(len);
    @(posedge clk_i);
    cfg_index <= CFG_ACCEPT_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_sites = (len < 3) ? 3 : (len > MAX_RING_LENGTH) ? MAX_RING_LENGTH : len;
    cur_thr   = thr;
  endtask

  task automatic send_random_item();
    logic [MODE_W-1:0] mode;
    logic [SITE_W-1:0] site;
    logic [UNI_W-1:0]  uni;
    logic [SPIN_W-1:0] word;
    int                ring;
    int                pick;
    pick = $urandom_range(0, 99);
    word = {$urandom, $urandom};
    site = SITE_W'($urandom);
    uni  = UNI_W'($urandom);
    ring = pick_ring();
    if (pick < 10) begin
      mode = MODE_LOAD;
      ring = $urandom_range(0, NUM_RINGS - 1);
    end else if (pick < 80) begin
      mode = MODE_FLIP;
      if ($urandom_range(0, 9) != 0) site = SITE_W'($urandom_range(0, cur_sites - 1));
      // Probe the acceptance bound right at the threshold.
      if ($urandom_range(0, 4) == 0 && cur_thr > 0 && cur_thr < THR_ONE)
        uni = UNI_W'(cur_thr - 1 + $urandom_range(0, 2));
    end else if (pick < 95) begin
      mode = MODE_READ;
    end else begin
      mode = MODE_READ_ALT;
    end
    send_item(mode, ring, site, uni, word);
  endtask

  initial begin : result_sink
    int stall_left;
    bit hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (sink_hold_req && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int lens [6];
    int thrs [6];
    int len;
    int thr;
    lens = '{3, 64, 0, 127, 2, 65};
    thrs = '{0, (1 << THR_W) - 1, THR_ONE, THR_ONE - 1, 1, THR_ONE / 2};
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    item_if.valid         = 1'b0;
    item_if.mode          = '0;
    item_if.ring_index    = '0;
    item_if.site_index    = '0;
    item_if.uniform_value = '0;
    item_if.spin_word     = '0;
    idle_off              = 1'b0;
    sink_hold_req         = 1'b0;
    last_ring             = 0;
    cur_sites             = int'(RING_LENGTH_RESET);
    cur_thr               = int'(ACCEPT_THRESHOLD_RESET);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset setup.
    send_item(MODE_LOAD, 0, '0, '0, '0);
    send_item(MODE_LOAD, NUM_RINGS - 1, '0, '0, '1);
    send_item(MODE_LOAD, 7, '0, '0, 64'h3);
    send_item(MODE_LOAD, 512, '0, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(MODE_READ, 0, '0, '0, '0);
    send_item(MODE_READ_ALT, NUM_RINGS - 1, '0, '0, '0);
    // Energy rise taken with the smallest uniform, then a fall back.
    send_item(MODE_FLIP, 0, 6'd0, 24'd0, '0);
    send_item(MODE_FLIP, 0, 6'd0, '1, '0);
    // Rise rejected at the largest uniform, accepted just below the bound,
    // rejected exactly at it.
    send_item(MODE_FLIP, NUM_RINGS - 1, 6'd49, '1, '0);
    send_item(MODE_FLIP, NUM_RINGS - 1, 6'd25,
              UNI_W'(ACCEPT_THRESHOLD_RESET - 1), '0);
    send_item(MODE_FLIP, NUM_RINGS - 1, 6'd40, UNI_W'(ACCEPT_THRESHOLD_RESET), '0);
    // Sites at and past the ring length.
    send_item(MODE_FLIP, NUM_RINGS - 1, 6'd50, 24'd0, '0);
    send_item(MODE_FLIP, NUM_RINGS - 1, 6'd63, 24'd0, '0);
    // Mixed neighbours give no energy change; an alternating ring falls at
    // every site, wrap included.
    send_item(MODE_FLIP, 7, 6'd1, '1, '0);
    send_item(MODE_FLIP, 512, 6'd0, '1, '0);
    send_item(MODE_LOAD, 513, '0, '0, {$urandom, $urandom});
    send_item(MODE_FLIP, 513, SITE_W'($urandom_range(0, 49)), UNI_W'($urandom), '0);
    send_item(MODE_READ, 7, '0, '0, '0);
    send_item(MODE_READ, 512, '0, '0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      if (p < 6) begin
        len = lens[p];
        thr = thrs[p];
      end else begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 64);
        thr = ($urandom_range(0, 1) == 0) ? $urandom_range(0, THR_ONE)
                                          : $urandom_range(0, (1 << THR_W) - 1);
      end
      set_config(len, thr);
      idle_off = (p == 4);
      // Hold the result side off while items keep coming.
      if (p == 2) sink_hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 7 && k == ITEMS_PER_PHASE / 2) drain_results();
        send_random_item();
      end
    end
    idle_off = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
